// File: sv/lfu_pkg.sv
// Shared widths, reset values and register codes for the LFU page replacement unit.
package lfu_pkg;

  localparam int MAX_PAGES_DEF   = 64;
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int PAGE_W      = 7;
  localparam int FRAME_OUT_W = 4;
  localparam int FAULT_W     = 32;
  localparam int PCOUNT_W    = 7;
  localparam int FCOUNT_W    = 5;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic REG_PAGE_COUNT  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RST  = 7'd64;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 5'd16;

endpackage

// File: sv/lfu_page_replacement_unit.sv
// Top level of the LFU page replacement unit: page table memory and its sequencer.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall   | in_page
//   out     | output    | out_valid / out_stall | out_hit, out_frame, out_evicted_valid,
//           |           |                       | out_evicted_page, out_fault_total,
//           |           |                       | out_out_of_range
//   cfg     | input     | APB write/read        | page_count (0x0), frame_count (0x4)
//
// A rejected reference goes from idle straight to finish; a hit or a fill into a free frame
// passes through read, evaluate and finish; a miss with every frame in use also passes
// through scan, scan end, evict and place: the victim scan reads one page-table entry per
// cycle through the single read port of the page-table memory. After reset the block clears
// the resident bits, one entry per cycle; in_stall stays high meanwhile, configuration
// writes are taken. in_stall is high from the accept until the block is back in idle. A
// finished result waits in the output register while the next item is taken.
module lfu_page_replacement_unit #(
  parameter int MAX_PAGES   = lfu_pkg::MAX_PAGES_DEF,
  parameter int MAX_FRAMES  = lfu_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lfu_pkg::PAGE_W-1:0]       in_page,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [lfu_pkg::FRAME_OUT_W-1:0]  out_frame,
  output logic                             out_evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]       out_evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0]      out_fault_total,
  output logic                             out_out_of_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfu_pkg::APB_AW-1:0]       paddr,
  input  logic [lfu_pkg::APB_DW-1:0]       pwdata,
  output logic [lfu_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import lfu_pkg::*;

  localparam int AB  = $clog2(MAX_PAGES);
  localparam int FB  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FLW = $clog2(MAX_FRAMES + 1);
  localparam int CW  = COUNT_WIDTH;
  localparam int NW  = 1 + FB + CW;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_READ     = 4'd2;
  localparam logic [3:0] ST_EVAL     = 4'd3;
  localparam logic [3:0] ST_SCAN     = 4'd4;
  localparam logic [3:0] ST_SCAN_END = 4'd5;
  localparam logic [3:0] ST_EVICT    = 4'd6;
  localparam logic [3:0] ST_PLACE    = 4'd7;
  localparam logic [3:0] ST_FINISH   = 4'd8;

  // page table: {resident, frame, use count}, entry i holds page i+1
  logic [NW-1:0] mem [MAX_PAGES];
  logic [NW-1:0] rd_data_r;
  logic [AB-1:0] ra, wa;
  logic [NW-1:0] wd;
  logic          we;

  logic          rd_res;
  logic [FB-1:0] rd_frame;
  logic [CW-1:0] rd_cnt;

  logic [3:0]           state_r, state_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [AB-1:0]        clr_idx_r, clr_idx_nxt;
  logic [FLW-1:0]       filled_r, filled_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic [AB-1:0]        scan_idx_r, scan_idx_nxt;
  logic [AB-1:0]        scan_prev_r, scan_prev_nxt;
  logic                 scan_pv_r, scan_pv_nxt;
  logic                 found_r, found_nxt;
  logic [CW-1:0]        best_r, best_nxt;
  logic [AB-1:0]        victim_r, victim_nxt;
  logic [FB-1:0]        vframe_r, vframe_nxt;

  logic                 res_hit_r, res_hit_nxt;
  logic [FB-1:0]        res_frame_r, res_frame_nxt;
  logic                 res_ev_r, res_ev_nxt;
  logic [PAGE_W-1:0]    res_evpage_r, res_evpage_nxt;
  logic                 res_bad_r, res_bad_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_hit_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic                 out_ev_r;
  logic [PAGE_W-1:0]    out_evpage_r;
  logic [FAULT_W-1:0]   out_fault_r;
  logic                 out_bad_r;

  logic [PCOUNT_W-1:0]  page_count_r;
  logic [FCOUNT_W-1:0]  frame_count_r;

  logic                 in_acc, in_bad, take;
  logic [AB-1:0]        page_addr;
  logic [FAULT_W-1:0]   fault_inc;

  assign rd_res   = rd_data_r[NW-1];
  assign rd_frame = rd_data_r[CW +: FB];
  assign rd_cnt   = rd_data_r[CW-1:0];

  assign in_acc    = in_valid && !in_stall;
  assign in_bad    = (in_page == '0) || (in_page > page_count_r) ||
                     (32'(in_page) > 32'(MAX_PAGES));
  assign page_addr = AB'(32'(page_r) - 32'd1);
  assign fault_inc = (&fault_r) ? fault_r : fault_r + 1'b1;
  // strict less keeps the lowest page number on a tie
  assign take      = scan_pv_r && rd_res && (!found_r || rd_cnt < best_r);

  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    clr_idx_nxt    = clr_idx_r;
    filled_nxt     = filled_r;
    fault_nxt      = fault_r;
    scan_idx_nxt   = scan_idx_r;
    scan_prev_nxt  = scan_prev_r;
    scan_pv_nxt    = scan_pv_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    victim_nxt     = victim_r;
    vframe_nxt     = vframe_r;
    res_hit_nxt    = res_hit_r;
    res_frame_nxt  = res_frame_r;
    res_ev_nxt     = res_ev_r;
    res_evpage_nxt = res_evpage_r;
    res_bad_nxt    = res_bad_r;
    out_load       = 1'b0;
    ra             = page_addr;
    we             = 1'b0;
    wa             = page_addr;
    wd             = '0;

    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_idx_r;
        wd = '0;
        if (32'(clr_idx_r) == 32'(MAX_PAGES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt = in_page;
          if (in_bad) begin
            res_hit_nxt    = 1'b0;
            res_frame_nxt  = '0;
            res_ev_nxt     = 1'b0;
            res_evpage_nxt = '0;
            res_bad_nxt    = 1'b1;
            state_nxt      = ST_FINISH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        res_bad_nxt    = 1'b0;
        res_ev_nxt     = 1'b0;
        res_evpage_nxt = '0;
        if (rd_res) begin
          we            = 1'b1;
          wd            = {1'b1, rd_frame, (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1};
          res_hit_nxt   = 1'b1;
          res_frame_nxt = rd_frame;
          state_nxt     = ST_FINISH;
        end else begin
          res_hit_nxt = 1'b0;
          fault_nxt   = fault_inc;
          if ((32'(filled_r) < 32'(frame_count_r)) && (32'(filled_r) < 32'(MAX_FRAMES))) begin
            we            = 1'b1;
            wd            = {1'b1, FB'(filled_r), CW'(1)};
            res_frame_nxt = FB'(filled_r);
            filled_nxt    = filled_r + 1'b1;
            state_nxt     = ST_FINISH;
          end else begin
            scan_idx_nxt = '0;
            scan_pv_nxt  = 1'b0;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read data comes through the read register, so it arrives in the cycle after its address
        ra = scan_idx_r;
        if (take) begin
          found_nxt  = 1'b1;
          best_nxt   = rd_cnt;
          victim_nxt = scan_prev_r;
          vframe_nxt = rd_frame;
        end
        scan_prev_nxt = scan_idx_r;
        scan_pv_nxt   = 1'b1;
        if (32'(scan_idx_r) == 32'(MAX_PAGES - 1)) begin
          state_nxt = ST_SCAN_END;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        if (take) begin
          found_nxt  = 1'b1;
          best_nxt   = rd_cnt;
          victim_nxt = scan_prev_r;
          vframe_nxt = rd_frame;
        end
        scan_pv_nxt = 1'b0;
        state_nxt   = ST_EVICT;
      end
      ST_EVICT: begin
        if (found_r) begin
          we        = 1'b1;
          wa        = victim_r;
          wd        = {1'b0, vframe_r, best_r};
          state_nxt = ST_PLACE;
        end else begin
          res_frame_nxt = '0;
          state_nxt     = ST_FINISH;
        end
      end
      ST_PLACE: begin
        we             = 1'b1;
        wd             = {1'b1, vframe_r, CW'(1)};
        res_frame_nxt  = vframe_r;
        res_ev_nxt     = 1'b1;
        res_evpage_nxt = PAGE_W'(32'(victim_r) + 32'd1);
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_idx_r     <= '0;
      filled_r      <= '0;
      fault_r       <= '0;
      scan_pv_r     <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      page_count_r  <= PAGE_COUNT_RST;
      frame_count_r <= FRAME_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      filled_r    <= filled_nxt;
      fault_r     <= fault_nxt;
      scan_pv_r   <= scan_pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_PAGE_COUNT:  page_count_r  <= pwdata[PCOUNT_W-1:0];
          REG_FRAME_COUNT: frame_count_r <= pwdata[FCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    scan_idx_r   <= scan_idx_nxt;
    scan_prev_r  <= scan_prev_nxt;
    best_r       <= best_nxt;
    victim_r     <= victim_nxt;
    vframe_r     <= vframe_nxt;
    res_hit_r    <= res_hit_nxt;
    res_frame_r  <= res_frame_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evpage_r <= res_evpage_nxt;
    res_bad_r    <= res_bad_nxt;
    if (out_load) begin
      out_hit_r    <= res_hit_r;
      out_frame_r  <= FRAME_OUT_W'(32'(res_frame_r));
      out_ev_r     <= res_ev_r;
      out_evpage_r <= res_evpage_r;
      out_fault_r  <= fault_r;
      out_bad_r    <= res_bad_r;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAGE_COUNT:  prdata = APB_DW'(page_count_r);
      REG_FRAME_COUNT: prdata = APB_DW'(frame_count_r);
      default:         prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_evpage_r;
  assign out_fault_total   = out_fault_r;
  assign out_out_of_range  = out_bad_r;

endmodule

// File: sv/lfu_checker.sv
// Port-level checker for the LFU page replacement unit, bound to the top level.
module lfu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_hit,
  input logic [lfu_pkg::FRAME_OUT_W-1:0]  out_frame,
  input logic                             out_evicted_valid,
  input logic [lfu_pkg::PAGE_W-1:0]       out_evicted_page,
  input logic [lfu_pkg::FAULT_W-1:0]      out_fault_total,
  input logic                             out_out_of_range
);
  import lfu_pkg::*;

  // one request at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in progress");

  a_evicted_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_hit && !out_evicted_valid && out_frame == '0)
    else $error("rejected request reports a lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit || out_evicted_valid) |-> !(out_hit && out_evicted_valid))
    else $error("hit reported together with an eviction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fault_total))
    else $error("stalled result changed");

endmodule

bind lfu_page_replacement_unit lfu_checker u_lfu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_frame         (out_frame),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total),
  .out_out_of_range  (out_out_of_range)
);

// File: tb/lfu_page_replacement_unit_tb.sv
// Testbench for the LFU page replacement unit: random and directed references, scoreboard check.
`timescale 1ns / 100ps

module lfu_page_replacement_unit_tb;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = MAX_PAGES_DEF + 8;
  localparam int USE_MAX       = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   ev_valid;
    logic [PAGE_W-1:0]      ev_page;
    logic [FAULT_W-1:0]     faults;
    logic                   bad;
  } page_reply_t;

  class lfu_scoreboard;
    bit                     resident [1:MAX_PAGES_DEF];
    logic [FRAME_OUT_W-1:0] frame_of [1:MAX_PAGES_DEF];
    int unsigned            uses [1:MAX_PAGES_DEF];
    int unsigned            filled;
    logic [FAULT_W-1:0]     faults;
    int unsigned            page_reg;
    int unsigned            frame_reg;
    page_reply_t            expected_replies [$];
    int                     errors;

    function new();
      page_reg  = PAGE_COUNT_RST;
      frame_reg = FRAME_COUNT_RST;
      filled    = 0;
      faults    = '0;
      errors    = 0;
      foreach (resident[i]) begin
        resident[i] = 1'b0;
        frame_of[i] = '0;
        uses[i]     = 0;
      end
    endfunction

    function int unsigned page_limit();
      return (page_reg > MAX_PAGES_DEF) ? MAX_PAGES_DEF : page_reg;
    endfunction

    function int unsigned frame_limit();
      return (frame_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_reg;
    endfunction

    function void write_reg(logic idx, int unsigned value);
      if (idx == REG_PAGE_COUNT) begin
        page_reg = value & 32'h7F;
      end else begin
        frame_reg = value & 32'h1F;
      end
    endfunction

    function page_reply_t resolve_reference(int unsigned pg);
      page_reply_t r;
      int unsigned victim;
      int unsigned best;
      int unsigned q;
      bit          found;
      r = '0;
      if (pg == 0 || pg > page_limit()) begin
        r.bad    = 1'b1;
        r.faults = faults;
        return r;
      end
      if (resident[pg]) begin
        if (uses[pg] < USE_MAX) uses[pg]++;
        r.hit    = 1'b1;
        r.frame  = frame_of[pg];
        r.faults = faults;
        return r;
      end
      if (faults != '1) faults++;
      r.faults = faults;
      if (filled < frame_limit()) begin
        resident[pg] = 1'b1;
        frame_of[pg] = FRAME_OUT_W'(filled);
        uses[pg]     = 1;
        filled++;
        r.frame = frame_of[pg];
        return r;
      end
      // Scan every resident page, strict less-than keeps the lowest page on a tie
      found  = 1'b0;
      victim = 0;
      best   = 0;
      for (q = 1; q <= MAX_PAGES_DEF; q++) begin
        if (resident[q] && (!found || uses[q] < best)) begin
          found  = 1'b1;
          best   = uses[q];
          victim = q;
        end
      end
      if (!found) return r;
      resident[victim] = 1'b0;
      resident[pg]     = 1'b1;
      frame_of[pg]     = frame_of[victim];
      uses[pg]         = 1;
      r.frame    = frame_of[pg];
      r.ev_valid = 1'b1;
      r.ev_page  = PAGE_W'(victim);
      return r;
    endfunction

    function void note_request(logic [PAGE_W-1:0] pg);
      expected_replies.push_back(resolve_reference(pg));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report_mismatch(string what, logic [FAULT_W-1:0] got, logic [FAULT_W-1:0] want);
      if (errors < PRINT_CAP)
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_reply(page_reply_t got);
      page_reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending", 0, 0);
        return;
      end
      want = expected_replies.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.frame !== want.frame) report_mismatch("frame", got.frame, want.frame);
      if (got.ev_valid !== want.ev_valid)
        report_mismatch("evicted_valid", got.ev_valid, want.ev_valid);
      if (got.ev_page !== want.ev_page)
        report_mismatch("evicted_page", got.ev_page, want.ev_page);
      if (got.faults !== want.faults) report_mismatch("fault_total", got.faults, want.faults);
      if (got.bad !== want.bad) report_mismatch("out_of_range", got.bad, want.bad);
    endtask
  endclass

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [PAGE_W-1:0]       in_page   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_hit;
  logic [FRAME_OUT_W-1:0]  out_frame;
  logic                    out_evicted_valid;
  logic [PAGE_W-1:0]       out_evicted_page;
  logic [FAULT_W-1:0]      out_fault_total;
  logic                    out_out_of_range;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [APB_AW-1:0]       paddr     = '0;
  logic [APB_DW-1:0]       pwdata    = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  logic                    calm = 1'b0;
  int unsigned             cycles = 0;
  lfu_scoreboard           board;

  lfu_page_replacement_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_out_of_range  (out_out_of_range),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lfu_page_replacement_unit_tb: errors");
      $finish;
    end
  end

  // Take replies and randomly hold the result channel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_reply({out_hit, out_frame, out_evicted_valid, out_evicted_page,
                         out_fault_total, out_out_of_range});
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Leave in_valid high on return; the next call or settle decides its next value
  task send_page(input logic [PAGE_W-1:0] pg);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page  <= pg;
    do @(posedge clk); while (in_stall);
    board.note_request(pg);
  endtask

  task settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_cfg(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task send_list(input int unsigned pages [$]);
    foreach (pages[i]) send_page(PAGE_W'(pages[i]));
  endtask

  // Mostly legal pages from a hot set a little larger than the frame pool
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned lim;
    int unsigned hot;
    lim = board.page_limit();
    if (lim == 0 || $urandom_range(99) < 12) begin
      if ($urandom_range(3) == 0) return '0;
      return PAGE_W'($urandom_range(lim + 1, 127));
    end
    hot = board.frame_limit() + 3;
    if (hot > lim) hot = lim;
    if ($urandom_range(99) < 65) return PAGE_W'($urandom_range(1, hot));
    return PAGE_W'($urandom_range(1, lim));
  endfunction

  initial begin
    int unsigned pc;
    int unsigned fc;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // No frames at all from reset, plus rejected pages
    write_cfg(REG_FRAME_COUNT, 0);
    send_list('{5, 0, 64, 65, 127});

    // Fill, hits, evictions with a tie on the smallest count
    settle();
    write_cfg(REG_FRAME_COUNT, 3);
    write_cfg(REG_PAGE_COUNT, 64);
    send_list('{1, 2, 3, 1, 1, 2, 4, 5, 5, 6, 64});

    // Page count lowered below a resident page: it is rejected yet still a victim
    settle();
    write_cfg(REG_PAGE_COUNT, 10);
    send_list('{64, 11, 7});

    // Frame count lowered below the fill level
    settle();
    write_cfg(REG_FRAME_COUNT, 1);
    send_list('{8, 8});

    // Oversized registers clamp to the maximum
    settle();
    write_cfg(REG_FRAME_COUNT, 31);
    write_cfg(REG_PAGE_COUNT, 127);
    send_list('{9, 64, 100, 127});

    // Build up one page's use count, then force evictions around it
    settle();
    calm <= 1'b1;
    write_cfg(REG_FRAME_COUNT, 2);
    write_cfg(REG_PAGE_COUNT, 64);
    repeat (40) send_page(1);
    send_list('{20, 21, 22, 23, 1});

    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: begin
          pc = 64;
          fc = 16;
        end
        1: begin
          pc = 127;
          fc = 31;
        end
        2: begin
          pc = 1;
          fc = 1;
        end
        default: begin
          case ($urandom_range(9))
            0: pc = 0;
            1: pc = 1;
            2: pc = 64;
            3: pc = $urandom_range(65, 127);
            default: pc = $urandom_range(2, 63);
          endcase
          case ($urandom_range(9))
            0: fc = 0;
            1: fc = 1;
            2: fc = 16;
            3: fc = $urandom_range(17, 31);
            default: fc = $urandom_range(2, 15);
          endcase
        end
      endcase
      settle();
      calm <= (seg == 4);
      write_cfg(REG_PAGE_COUNT, pc);
      write_cfg(REG_FRAME_COUNT, fc);
      repeat (190) send_page(pick_page());
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch("requests left without reply", board.pending(), 0);
    if (board.errors == 0)
      $display("lfu_page_replacement_unit_tb: clean");
    else
      $display("lfu_page_replacement_unit_tb: errors");
    $finish;
  end

endmodule
